FILE: hdl/lrni_pkg.sv
`timescale 1ns / 1ps
package lrni_pkg;

  // field widths
  localparam int unsigned COORD_W = 24;
  localparam int unsigned NOISE_W = 16;
  localparam int unsigned RANGE_W = 24;
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned TERR_W  = 16;
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned IDX_W   = 4;

  // internal arithmetic widths
  localparam int unsigned ERR_W   = 26;  // error term incl. interpolation overshoot
  localparam int unsigned RP_W    = 36;  // noisy range in 2^-16 m
  localparam int unsigned ACC_W   = 61;  // coord * noisy range + rounding
  localparam int unsigned NUM_W   = 53;  // divider numerator
  localparam int unsigned QUO_W   = 54;  // divider quotient
  localparam int unsigned ENTRY_W = DIST_W + TERR_W;

  // input packing
  localparam int unsigned IN_DATA_W = 136;
  localparam int unsigned OUT_DATA_W = 72;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // error modes
  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_PROP  = 2'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_AMOUNT  = 2'd1;
  localparam logic [1:0] CFG_ENTRIES = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [NOISE_W-1:0] noise;
  } point_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_SUM,
    ST_SQRT,
    ST_ERR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_IMUL,
    ST_IDIV_GO,
    ST_IDIV_WAIT,
    ST_RP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_CDIV_GO,
    ST_CDIV_WAIT,
    ST_OUT
  } state_t;

  localparam logic signed [QUO_W-1:0] Q_MAX = 54'sd8388607;
  localparam logic signed [QUO_W-1:0] Q_MIN = -54'sd8388608;

  // clamp a quotient to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [QUO_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > Q_MAX) begin
      res = 24'sh7FFFFF;
    end else if (v < Q_MIN) begin
      res = -24'sh800000;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/lrni_ram.sv
`timescale 1ns / 1ps
module lrni_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/lrni_div.sv
`timescale 1ns / 1ps
module lrni_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [lrni_pkg::NUM_W-1:0]   num,
  input  logic [lrni_pkg::DIST_W-1:0]         den,
  output logic                                busy,
  output logic                                done,
  output logic signed [lrni_pkg::QUO_W-1:0]   quo
);
  import lrni_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [NUM_W-1:0]  sh_r;
  logic [DIST_W-1:0] rem_r;
  logic [DIST_W-1:0] den_r;

  logic [DIST_W:0]   cur_c;
  logic              qbit_c;
  logic [DIST_W:0]   diff_c;
  logic [NUM_W-1:0]  mag_c;
  logic signed [QUO_W-1:0] qmag_c;

  // one restoring step per cycle
  always_comb begin
    cur_c  = {rem_r, sh_r[NUM_W-1]};
    diff_c = cur_c - {1'b0, den_r};
    qbit_c = (cur_c >= {1'b0, den_r});
    mag_c  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      sh_r  <= mag_c;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= qbit_c ? diff_c[DIST_W-1:0] : cur_c[DIST_W-1:0];
      sh_r  <= {sh_r[NUM_W-2:0], qbit_c};
    end
  end

  // floor correction for negative numerators
  always_comb begin
    qmag_c = $signed({1'b0, sh_r});
    if (!neg_r) begin
      quo = qmag_c;
    end else if (rem_r != '0) begin
      quo = -(qmag_c + QUO_W'(1));
    end else begin
      quo = -qmag_c;
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

FILE: hdl/lrni_front.sv
`timescale 1ns / 1ps
module lrni_front #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lrni_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [0:0]                        in_tuser,
  input  logic                              back_busy,
  output logic                              tbl_wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]    tbl_wr_addr,
  output logic [lrni_pkg::ENTRY_W-1:0]      tbl_wr_data,
  output logic                              q_valid,
  output lrni_pkg::point_t                  q_data,
  input  logic                              q_pop
);
  import lrni_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [IDX_W-1:0]  idx_c;
  logic [DIST_W-1:0] dist_c;
  logic [TERR_W-1:0] terr_c;
  point_t            pt_c;
  logic              accept_c;
  logic              push_c;

  point_t            q_mem_r [2];
  logic              wptr_r;
  logic              rptr_r;
  logic [1:0]        cnt_r;

  // unpack the request
  always_comb begin
    idx_c    = in_tdata[3:0];
    dist_c   = in_tdata[27:4];
    terr_c   = in_tdata[43:28];
    pt_c.x   = in_tdata[67:44];
    pt_c.y   = in_tdata[91:68];
    pt_c.z   = in_tdata[115:92];
    pt_c.noise = in_tdata[131:116];
  end

  // loads wait until every queued point has finished with the table
  always_comb begin
    if (in_tuser[0] == CMD_POINT) begin
      in_tready = (cnt_r != 2'd2);
    end else begin
      in_tready = (cnt_r == 2'd0) && !back_busy;
    end
    accept_c = in_tvalid && in_tready;
    push_c   = accept_c && (in_tuser[0] == CMD_POINT);
  end

  // table write
  assign tbl_wr_en   = accept_c && (in_tuser[0] == CMD_LOAD) &&
                       (32'(idx_c) < TABLE_DEPTH);
  assign tbl_wr_addr = AW'(idx_c);
  assign tbl_wr_data = {terr_c, dist_c};

  // two-entry point queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push_c) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      if (push_c && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push_c && q_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_c) begin
      q_mem_r[wptr_r] <= pt_c;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = q_mem_r[rptr_r];

endmodule

FILE: hdl/lrni_back.sv
`timescale 1ns / 1ps
module lrni_back #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  lrni_pkg::point_t                  q_data,
  output logic                              q_pop,
  output logic                              busy,
  input  logic [1:0]                        error_mode,
  input  logic [lrni_pkg::AMT_W-1:0]        error_amount,
  input  logic [4:0]                        table_entries,
  output logic [$clog2(TABLE_DEPTH)-1:0]    tbl_rd_addr,
  input  logic [lrni_pkg::ENTRY_W-1:0]      tbl_rd_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lrni_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import lrni_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] coord_r [3];
  logic signed [NOISE_W-1:0] nz_r;
  logic [46:0]               sq_r [3];
  logic [47:0]               rad_r;
  logic [25:0]               rem_r;
  logic [RANGE_W-1:0]        r_r;
  logic [4:0]                cnt_r;
  logic signed [ERR_W-1:0]   e_r;
  logic signed [RP_W-1:0]    rp_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [41:0]        ph_r;
  logic [1:0]                k_r;
  logic signed [COORD_W-1:0] res_r [3];
  logic [CW-1:0]             i_r;
  logic [CW-1:0]             n_r;
  logic [DIST_W-1:0]         d0_r;
  logic [DIST_W-1:0]         d1_r;
  logic [TERR_W-1:0]         e0_r;
  logic [TERR_W-1:0]         e1_r;
  logic signed [NUM_W-1:0]   prod_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  // divider hookup
  logic                      div_start;
  logic signed [NUM_W-1:0]   div_num;
  logic [DIST_W-1:0]         div_den;
  logic                      div_busy;
  logic                      div_done;
  logic signed [QUO_W-1:0]   div_quo;

  // combinational helpers
  logic signed [COORD_W-1:0] coord_c;
  logic signed [47:0]        sqx_c, sqy_c, sqz_c;
  logic [27:0]               cur_c, sub_c;
  logic [39:0]               prop_c;
  logic signed [41:0]        nze_c;
  logic signed [32:0]        zero_c;
  logic signed [42:0]        plo_c;
  logic signed [41:0]        phi_c;
  logic signed [16:0]        diff_c;
  logic signed [41:0]        iprod_c;
  logic [8:0]                ent9_c, dep9_c;
  logic [CW-1:0]             n_c;
  logic [DIST_W-1:0]         t_c;
  logic [DIST_W-1:0]         dist_c;
  logic [TERR_W-1:0]         terr_c;
  logic [CW-1:0]             i_inc_c;
  logic                      out_free_c;

  always_comb begin
    coord_c = coord_r[k_r];
    sqx_c   = coord_r[0] * coord_r[0];
    sqy_c   = coord_r[1] * coord_r[1];
    sqz_c   = coord_r[2] * coord_r[2];
    cur_c   = {rem_r, rad_r[47:46]};
    sub_c   = {2'b00, r_r, 2'b01};
    prop_c  = error_amount * r_r;
    nze_c   = nz_r * e_r;
    zero_c  = nz_r * $signed({1'b0, error_amount});
    plo_c   = coord_c * $signed({1'b0, rp_r[17:0]});
    phi_c   = coord_c * $signed(rp_r[RP_W-1:18]);
    diff_c  = $signed({1'b0, e1_r}) - $signed({1'b0, e0_r});
    iprod_c = diff_c * $signed({1'b0, r_r - d0_r});
    ent9_c  = 9'(table_entries);
    dep9_c  = 9'(TABLE_DEPTH);
    n_c     = CW'((ent9_c > dep9_c) ? dep9_c : ent9_c);
    t_c     = {r_r[RANGE_W-1:8], 8'h00};
    dist_c  = tbl_rd_data[DIST_W-1:0];
    terr_c  = tbl_rd_data[ENTRY_W-1:DIST_W];
    i_inc_c = i_r + 1'b1;
    out_free_c = !out_valid_r || out_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (q_valid) state_nxt = ST_SQ;
      ST_SQ:        state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_SQRT;
      ST_SQRT:      if (cnt_r == 5'd1) state_nxt = ST_ERR;
      ST_ERR: begin
        if (r_r == '0) begin
          state_nxt = ST_OUT;
        end else if (error_mode == MODE_CONST || error_mode == MODE_PROP) begin
          state_nxt = ST_RP;
        end else if (n_c == '0) begin
          state_nxt = ST_RP;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:   state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (dist_c <= t_c) begin
          if (dist_c == t_c || i_inc_c == n_r) begin
            state_nxt = ST_RP;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end else if (i_r == '0) begin
          state_nxt = ST_RP;
        end else begin
          state_nxt = ST_IMUL;
        end
      end
      ST_IMUL:      state_nxt = ST_IDIV_GO;
      ST_IDIV_GO:   state_nxt = ST_IDIV_WAIT;
      ST_IDIV_WAIT: if (div_done) state_nxt = ST_RP;
      ST_RP:        state_nxt = ST_MUL_LO;
      ST_MUL_LO:    state_nxt = ST_MUL_HI;
      ST_MUL_HI:    state_nxt = ST_ACC;
      ST_ACC:       state_nxt = ST_CDIV_GO;
      ST_CDIV_GO:   state_nxt = ST_CDIV_WAIT;
      ST_CDIV_WAIT: begin
        if (div_done) begin
          state_nxt = (k_r == 2'd2) ? ST_OUT : ST_MUL_LO;
        end
      end
      ST_OUT:       if (out_free_c) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = (state_r == ST_IDLE) && q_valid;
    busy      = (state_r != ST_IDLE);
    div_start = (state_r == ST_IDIV_GO) || (state_r == ST_CDIV_GO);
    if (state_r == ST_IDIV_GO) begin
      div_num = prod_r;
      div_den = d1_r - d0_r;
    end else begin
      div_num = acc_r[ACC_W-1:8];
      div_den = r_r;
    end
    tbl_rd_addr = i_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free_c) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        coord_r[0] <= q_data.x;
        coord_r[1] <= q_data.y;
        coord_r[2] <= q_data.z;
        nz_r       <= q_data.noise;
      end
      ST_SQ: begin
        sq_r[0] <= sqx_c[46:0];
        sq_r[1] <= sqy_c[46:0];
        sq_r[2] <= sqz_c[46:0];
      end
      ST_SUM: begin
        rad_r <= 48'(sq_r[0]) + 48'(sq_r[1]) + 48'(sq_r[2]);
        rem_r <= '0;
        r_r   <= '0;
        cnt_r <= 5'd24;
      end
      ST_SQRT: begin
        // two radicand bits per cycle
        if (cur_c >= sub_c) begin
          rem_r <= 26'(cur_c - sub_c);
          r_r   <= {r_r[RANGE_W-2:0], 1'b1};
        end else begin
          rem_r <= cur_c[25:0];
          r_r   <= {r_r[RANGE_W-2:0], 1'b0};
        end
        rad_r <= {rad_r[45:0], 2'b00};
        cnt_r <= cnt_r - 5'd1;
      end
      ST_ERR: begin
        // zero range: only the constant mode moves the point
        res_r[0] <= (error_mode == MODE_CONST) ? COORD_W'($signed(zero_c[32:15])) : '0;
        res_r[1] <= '0;
        res_r[2] <= '0;
        i_r      <= '0;
        n_r      <= n_c;
        if (error_mode == MODE_CONST) begin
          e_r <= $signed(ERR_W'(error_amount));
        end else if (error_mode == MODE_PROP) begin
          e_r <= $signed(ERR_W'(prop_c[39:16]));
        end else begin
          e_r <= '0;
        end
      end
      ST_SCAN_CMP: begin
        if (dist_c <= t_c) begin
          d0_r <= dist_c;
          e0_r <= terr_c;
          i_r  <= i_inc_c;
          // exact hit or last valid entry
          e_r  <= $signed(ERR_W'(terr_c));
        end else begin
          d1_r <= dist_c;
          e1_r <= terr_c;
          e_r  <= '0;
        end
      end
      ST_IMUL: begin
        prod_r <= NUM_W'(iprod_c);
      end
      ST_IDIV_WAIT: begin
        if (div_done) begin
          e_r <= $signed(ERR_W'(e0_r)) + div_quo[ERR_W-1:0];
        end
      end
      ST_RP: begin
        rp_r <= $signed({4'b0, r_r, 8'h00}) + RP_W'($signed(nze_c[41:7]));
        k_r  <= 2'd0;
      end
      ST_MUL_LO: begin
        acc_r <= ACC_W'(plo_c);
      end
      ST_MUL_HI: begin
        ph_r <= phi_c;
      end
      ST_ACC: begin
        acc_r <= acc_r + (ACC_W'(ph_r) <<< 18) + $signed({30'b0, r_r, 7'b0});
      end
      ST_CDIV_WAIT: begin
        if (div_done) begin
          res_r[k_r] <= sat_coord(div_quo);
          k_r        <= k_r + 2'd1;
        end
      end
      ST_OUT: begin
        if (out_free_c) begin
          out_data_r <= {res_r[2], res_r[1], res_r[0]};
        end
      end
      default: begin
      end
    endcase
  end

  lrni_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_busy)
    else $error("divider busy while back end idle");

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_RD) |-> (i_r < n_r))
    else $error("table scan past valid entries");

endmodule

FILE: hdl/lidar_range_noise_injector_unit.sv
`timescale 1ns / 1ps
// Range noise injector for sensor-relative points. A point request
// (tuser = 1) runs longer in the table modes, by a scan step per table
// entry scanned and one more division when the table mode interpolates;
// the time is set by the shared divider, which makes one quotient bit
// per cycle for each of the three coordinates, and by the square root.
// Up to two point requests queue ahead of the worker. A table load
// request (tuser = 0) is only accepted once all earlier points have
// left the worker. The result register lets the next point run while
// the previous result waits.
module lidar_range_noise_injector_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // table_index, table_distance, table_error, point_x, point_y, point_z, noise
  input  logic [lrni_pkg::IN_DATA_W-1:0]      in_tdata,
  // command
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_x, out_y, out_z
  output logic [lrni_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_wdata
);
  import lrni_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [1:0]       mode_r;
  logic [AMT_W-1:0] amount_r;
  logic [4:0]       entries_r;

  logic               back_busy;
  logic               tbl_wr_en;
  logic [AW-1:0]      tbl_wr_addr;
  logic [ENTRY_W-1:0] tbl_wr_data;
  logic [AW-1:0]      tbl_rd_addr;
  logic [ENTRY_W-1:0] tbl_rd_data;
  logic               q_valid;
  point_t             q_data;
  logic               q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_CONST;
      amount_r  <= '0;
      entries_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:    mode_r    <= cfg_wdata[1:0];
        CFG_AMOUNT:  amount_r  <= cfg_wdata;
        CFG_ENTRIES: entries_r <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  lrni_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .back_busy   (back_busy),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop)
  );

  lrni_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  lrni_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .busy          (back_busy),
    .error_mode    (mode_r),
    .error_amount  (amount_r),
    .table_entries (entries_r),
    .tbl_rd_addr   (tbl_rd_addr),
    .tbl_rd_data   (tbl_rd_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule

FILE: dv/lidar_range_noise_injector_unit_tb.sv
`timescale 1ns / 1ps
module lidar_range_noise_injector_unit_tb;
  import lrni_pkg::*;

  localparam logic [1:0] MODE_TABLE     = 2'd2;
  localparam logic [1:0] MODE_TABLE_ALT = 2'd3;
  localparam int         DEPTH          = 16;
  localparam int         DRAIN_CYCLES   = 400;

  typedef enum logic [1:0] {ROW_LOAD, ROW_POINT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  idx;    // table index, or cfg mode
    logic [23:0] tdist;  // table distance, or cfg entry count
    logic [15:0] err;    // table error, or cfg amount
    logic signed [23:0] x, y, z;
    logic signed [15:0] noise;
    bit          typed;  // expected point typed in below
    logic signed [23:0] ex, ey, ez;
  } stim_row_t;

  typedef struct packed {
    logic signed [23:0] x, y, z;
  } noisy_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_MODE;
  logic [15:0] cfg_wdata = '0;

  // shadow of the block's settings and table
  logic [1:0]  cur_mode;
  logic [15:0] cur_amount;
  logic [4:0]  cur_entries;
  longint      dist_mem [DEPTH];
  longint      err_mem  [DEPTH];

  noisy_point_t expected_points [$];
  int in_idle_pct = 23;
  int out_idle_pct = 23;
  int fail_count = 0;
  int n_points = 0;
  int n_loads = 0;
  int n_results = 0;

  always #10 clk = ~clk;

  lidar_range_noise_injector_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // floor division on signed values
  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  function automatic longint range_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 48;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // error amplitude from the distance table
  function automatic longint table_error_for(longint r);
    int n;
    int i;
    longint t;
    n = (cur_entries > DEPTH) ? DEPTH : cur_entries;
    i = 0;
    t = r & ~longint'(255);
    while (i < n && dist_mem[i] <= t) begin
      if (dist_mem[i] == t) return err_mem[i];
      i++;
    end
    if (i == 0) return 0;
    if (i >= n) return err_mem[n-1];
    return err_mem[i-1] + floor_div((err_mem[i] - err_mem[i-1]) * (r - dist_mem[i-1]),
                                    dist_mem[i] - dist_mem[i-1]);
  endfunction

  function automatic noisy_point_t noisy_point(logic signed [23:0] px, logic signed [23:0] py,
                                              logic signed [23:0] pz,
                                              logic signed [15:0] pn);
    noisy_point_t res;
    longint x, y, z, nz, r, e, rp, den;
    x = px;
    y = py;
    z = pz;
    nz = pn;
    r = range_sqrt(longint'(x * x + y * y + z * z));
    if (r == 0) begin
      res.x = (cur_mode == MODE_CONST) ? clamp24(floor_div(nz * cur_amount, 32768)) : '0;
      res.y = '0;
      res.z = '0;
      return res;
    end
    if (cur_mode == MODE_CONST) e = cur_amount;
    else if (cur_mode == MODE_PROP) e = (longint'(cur_amount) * r) >>> 16;
    else e = table_error_for(r);
    rp = r * 256 + floor_div(nz * e, 128);
    den = r * 256;
    res.x = clamp24(floor_div(2 * x * rp + den, 2 * den));
    res.y = clamp24(floor_div(2 * y * rp + den, 2 * den));
    res.z = clamp24(floor_div(2 * z * rp + den, 2 * den));
    return res;
  endfunction

  // in_tdata: table_index, table_distance, table_error, point_x, point_y, point_z, noise
  function automatic logic [IN_DATA_W-1:0] pack_request(logic [3:0] idx, logic [23:0] tdist,
                                                        logic [15:0] err,
                                                        logic [23:0] x, logic [23:0] y,
                                                        logic [23:0] z, logic [15:0] nz);
    return {4'b0, nz, z, y, x, err, tdist, idx};
  endfunction

  // send one request; shadow state and expectations update on acceptance
  task automatic send_request(logic cmd, logic [3:0] idx, logic [23:0] tdist,
                              logic [15:0] err, logic signed [23:0] x,
                              logic signed [23:0] y, logic signed [23:0] z,
                              logic signed [15:0] nz, bit typed, noisy_point_t typed_pt);
    noisy_point_t pt;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= pack_request(idx, tdist, err, x, y, z, nz);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      dist_mem[idx] = tdist;
      err_mem[idx] = err;
      n_loads++;
    end else begin
      pt = noisy_point(x, y, z, nz);
      if (typed && pt != typed_pt) begin
        $error("typed row disagrees with predictor: %0d %0d %0d", pt.x, pt.y, pt.z);
        fail_count++;
      end
      expected_points.insert(expected_points.size(), typed ? typed_pt : pt);
      n_points++;
    end
  endtask

  // let the block settle: every result out plus a load's worth of slack
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] mode, logic [15:0] amount, logic [4:0] entries);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_wdata <= {14'b0, mode};
    @(posedge clk);
    cfg_index <= CFG_AMOUNT;
    cfg_wdata <= amount;
    @(posedge clk);
    cfg_index <= CFG_ENTRIES;
    cfg_wdata <= {11'b0, entries};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = mode;
    cur_amount = amount;
    cur_entries = entries;
  endtask

  function automatic logic signed [23:0] rand_coord(int cls);
    if (cls == 0) return '0;
    if (cls <= 3) return $urandom();
    return $signed($urandom_range(1 << 20)) - (1 << 19);
  endfunction

  function automatic stim_row_t pt_row(int x, int y, int z, int nz, bit typed = 0,
                                       int ex = 0, int ey = 0, int ez = 0);
    stim_row_t row;
    row = '{ROW_POINT, 0, 0, 0, x, y, z, nz, typed, ex, ey, ez};
    return row;
  endfunction

  function automatic stim_row_t ld_row(int idx, int tdist, int err);
    stim_row_t row;
    row = '{ROW_LOAD, idx, tdist, err, 0, 0, 0, 0, 0, 0, 0, 0};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(int mode, int amount, int entries);
    stim_row_t row;
    row = '{ROW_CFG, mode, entries, amount, 0, 0, 0, 0, 0, 0, 0, 0};
    return row;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    noisy_point_t exp_pt;
    logic signed [23:0] got_x, got_y, got_z;
    if (rst_n && out_tvalid && out_tready) begin
      got_x = out_tdata[23:0];
      got_y = out_tdata[47:24];
      got_z = out_tdata[71:48];
      n_results++;
      if (expected_points.size() == 0) begin
        $error("result with nothing expected: %0d %0d %0d", got_x, got_y, got_z);
        fail_count++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (got_x !== exp_pt.x) begin
          $error("out_x expected %0d actual %0d", exp_pt.x, got_x);
          fail_count++;
        end
        if (got_y !== exp_pt.y) begin
          $error("out_y expected %0d actual %0d", exp_pt.y, got_y);
          fail_count++;
        end
        if (got_z !== exp_pt.z) begin
          $error("out_z expected %0d actual %0d", exp_pt.z, got_z);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #80_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    noisy_point_t typed_pt;
    int cls;
    logic [1:0] mode;
    logic [15:0] amount;
    logic [4:0] entries;
    logic signed [15:0] nz;
    for (int i = 0; i < DEPTH; i++) begin
      dist_mem[i] = 0;
      err_mem[i] = 0;
    end
    cur_mode = MODE_CONST;
    cur_amount = '0;
    cur_entries = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: extremes, each mode and the special ranges
    rows.insert(rows.size(), pt_row(0, 0, 0, 0, 1, 0, 0, 0));
    rows.insert(rows.size(), pt_row(8388607, 0, 0, -32768, 1, 8388607, 0, 0));
    rows.insert(rows.size(), cfg_row(MODE_CONST, 256, 0));
    rows.insert(rows.size(), pt_row(0, 0, 0, 32767, 1, 255, 0, 0));
    rows.insert(rows.size(), pt_row(0, 0, 0, -32768, 1, -256, 0, 0));
    rows.insert(rows.size(), pt_row(-8388608, -8388608, -8388608, 32767));
    rows.insert(rows.size(), pt_row(1, 0, 0, -32768));
    rows.insert(rows.size(), cfg_row(MODE_PROP, 65535, 0));
    rows.insert(rows.size(), pt_row(0, 0, 0, 32767, 1, 0, 0, 0));
    rows.insert(rows.size(), pt_row(3000, 4000, 0, 12345));
    rows.insert(rows.size(), pt_row(8388607, 8388607, 8388607, -32768));
    rows.insert(rows.size(), ld_row(0, 'h000100, 100));
    rows.insert(rows.size(), ld_row(1, 'h000A00, 500));
    rows.insert(rows.size(), ld_row(2, 'h002000, 50));
    rows.insert(rows.size(), ld_row(3, 'h010000, 2000));
    rows.insert(rows.size(), cfg_row(MODE_TABLE, 0, 4));
    rows.insert(rows.size(), pt_row('h80, 0, 0, 32767, 1, 'h80, 0, 0));
    rows.insert(rows.size(), pt_row('hA00, 0, 0, 32767));
    rows.insert(rows.size(), pt_row(0, 'h1234, 0, -20000));
    rows.insert(rows.size(), pt_row(0, 0, -'h20000, 32767));
    rows.insert(rows.size(), cfg_row(MODE_TABLE_ALT, 0, 0));
    rows.insert(rows.size(), pt_row(-5000, 7000, 100, 32767, 1, -5000, 7000, 100));
    rows.insert(rows.size(), pt_row(0, 0, 0, -32768, 1, 0, 0, 0));
    foreach (rows[i]) begin
      typed_pt = '{rows[i].ex, rows[i].ey, rows[i].ez};
      case (rows[i].kind)
        ROW_CFG: begin
          set_config(rows[i].idx[1:0], rows[i].err, rows[i].tdist[4:0]);
        end
        ROW_LOAD: begin
          send_request(CMD_LOAD, rows[i].idx, rows[i].tdist, rows[i].err, 0, 0, 0, 0, 0,
                       typed_pt);
        end
        default: begin
          send_request(CMD_POINT, 0, 0, 0, rows[i].x, rows[i].y, rows[i].z, rows[i].noise,
                       rows[i].typed, typed_pt);
        end
      endcase
    end

    // fill the whole table, ascending, half the distances on whole metres
    for (int i = 0; i < DEPTH; i++) begin
      send_request(CMD_LOAD, i, i * 32768 + ((i % 2) ? $urandom_range(32767)
                   : ($urandom_range(127) << 8)), $urandom(), 0, 0, 0, 0, 0, typed_pt);
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < 8; ph++) begin
      mode = (ph < 4) ? ph[1:0] : $urandom_range(3);
      case ($urandom_range(3))
        0: amount = 16'd0;
        1: amount = 16'hFFFF;
        default: amount = $urandom();
      endcase
      entries = (ph == 2) ? 5'd16 : (ph == 6) ? 5'd0 : $urandom_range(16);
      in_idle_pct = (ph == 5) ? 0 : 23;
      out_idle_pct = (ph == 5) ? 0 : 23;
      set_config(mode, amount, entries);
      for (int k = 0; k < 190; k++) begin
        if (k == 95 && ph == 3) drain();
        case ($urandom_range(9))
          0: nz = 16'sh8000;
          1: nz = 16'sh7FFF;
          default: nz = $urandom();
        endcase
        if ($urandom_range(9) == 0) begin
          send_request(CMD_LOAD, $urandom(), $urandom(), $urandom(), 0, 0, 0, 0, 0, typed_pt);
        end else begin
          cls = $urandom_range(9);
          send_request(CMD_POINT, 0, 0, 0, rand_coord(cls), rand_coord(cls), rand_coord(cls),
                       nz, 0, typed_pt);
        end
      end
    end

    drain();
    $display("covered %0d points and %0d table loads, %0d results checked",
             n_points, n_loads, n_results);
    $display("all four error modes, table sizes 0..16, zero and saturating ranges");
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
